>>> sv/lss_pkg.sv
// Shared types and constants for the LED strip frame serializer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lss_pkg;

  // command codes carried in the input tuser
  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_SCALE  = 3'd0;
  localparam cmd_t CMD_BLEND  = 3'd1;
  localparam cmd_t CMD_MIRROR = 3'd2;
  localparam cmd_t CMD_READ   = 3'd3;
  localparam cmd_t CMD_START  = 3'd4;
  localparam cmd_t CMD_TICK   = 3'd5;

  // configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SHORT_WAIT = 1'd0;
  localparam cfg_idx_t CFG_LONG_WAIT  = 1'd1;

  localparam logic [7:0] SHORT_WAIT_RST = 8'd2;
  localparam logic [7:0] LONG_WAIT_RST  = 8'd7;

  localparam int BITS_PER_PIXEL = 24;
  localparam int BITS_PER_BYTE  = 8;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

  // one pixel, green in the top byte so bit 23 goes out first
  typedef struct packed {
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } rgb_t;

  typedef logic signed [11:0] frac_t;

endpackage

`default_nettype wire

>>> sv/lss_color_unit.sv
// Color arithmetic: Q8 scaled write and clamped Q8 blend for one pixel.
// Purely combinational; uses lss_pkg.
`default_nettype none

module lss_color_unit (
  input  lss_pkg::rgb_t  color_a,
  input  lss_pkg::rgb_t  color_b,
  input  lss_pkg::frac_t fraction,
  input  logic           blend,
  output lss_pkg::rgb_t  color_out
);
  import lss_pkg::*;

  // c * f / 256 toward zero, clamped to 0..255
  function automatic logic [7:0] scale_chan(input logic [7:0] c, input frac_t f);
    logic signed [20:0] p;
    p = $signed({1'b0, c}) * f;
    if (p <= 21'sd0)
      scale_chan = 8'd0;
    else if (p[20:16] != 5'd0)
      scale_chan = 8'hFF;
    else
      scale_chan = p[15:8];
  endfunction

  // (f*a + (256-f)*b) / 256 for f in 0..256
  function automatic logic [7:0] blend_chan(input logic [7:0] a, input logic [7:0] b,
                                            input logic [8:0] f);
    logic [16:0] s;
    s = 17'(f * a) + 17'((9'd256 - f) * b);
    blend_chan = s[16] ? 8'hFF : s[15:8];
  endfunction

  logic [8:0] f9;
  logic       f_over;
  logic       f_neg;

  assign f9     = fraction[8:0];
  assign f_neg  = fraction[11];
  assign f_over = !fraction[11] && (fraction > 12'sd256);

  // per-channel select between scale, first color, second color and blend
  always_comb begin
    if (!blend) begin
      color_out.green = scale_chan(color_a.green, fraction);
      color_out.red   = scale_chan(color_a.red,   fraction);
      color_out.blue  = scale_chan(color_a.blue,  fraction);
    end else if (f_over) begin
      color_out = color_a;
    end else if (f_neg) begin
      color_out = color_b;
    end else begin
      color_out.green = blend_chan(color_a.green, color_b.green, f9);
      color_out.red   = blend_chan(color_a.red,   color_b.red,   f9);
      color_out.blue  = blend_chan(color_a.blue,  color_b.blue,  f9);
    end
  end

endmodule

`default_nettype wire

>>> sv/lss_frame_store.sv
// Frame buffer: one 24-bit row per pixel, per-row valid bits, registered read
// with write-to-read forwarding. Uses lss_pkg.
`default_nettype none

module lss_frame_store #(
  parameter int PIXELS = 64,
  parameter int ROW_W  = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [ROW_W-1:0]     rd_addr,
  output lss_pkg::rgb_t        rd_data,
  input  logic                 wr_en,
  input  logic [ROW_W-1:0]     wr_addr,
  input  lss_pkg::rgb_t        wr_data
);
  import lss_pkg::*;

  rgb_t              mem [PIXELS];
  logic [PIXELS-1:0] row_vld_r;
  rgb_t              mem_q_r;
  logic              vld_q_r;
  logic              fwd_r;
  rgb_t              fwd_data_r;

  // storage array, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // row valid bits: an unwritten row reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  // read-side flags, forward a write to the row being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_q_r <= 1'b0;
      fwd_r   <= 1'b0;
    end else if (rd_en) begin
      vld_q_r <= row_vld_r[rd_addr];
      fwd_r   <= wr_en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : (vld_q_r ? mem_q_r : '0);

endmodule

`default_nettype wire

>>> sv/led_strip_frame_serializer.sv
// Top level of the LED strip frame serializer: input register, frame store
// access stage and result register. Uses lss_pkg, lss_color_unit, lss_frame_store.
//
//  channel  dir  handshake                 payload
//  in_      in   in_tvalid/in_tready       in_tuser command, in_tdata fields
//  out_     out  out_tvalid/out_tready     out_tdata fields, out_tlast frame_done
//  cfg_     in   cfg_wr_en                 cfg_addr index, cfg_wr_data value
//
// One item per clock sustained while out_tready stays high; each item passes through
// three stages in order (input register, frame store read, result register) before
// its result is offered. Forwarding from the write stage to the store read lets
// back-to-back items see each other's writes.
// Reset is synchronous; frame store rows carry valid bits, so no clearing pass.
// Each stage holds while the one after it is full and stalled.
`default_nettype none

module led_strip_frame_serializer #(
  parameter int PIXELS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [5:0] pixel_index, [13:6] green_a, [21:14] red_a, [29:22] blue_a,
  // [37:30] green_b, [45:38] red_b, [53:46] blue_b, [65:54] fraction
  input  logic [lss_pkg::IN_DATA_W-1:0] in_tdata,
  input  lss_pkg::cmd_t                 in_tuser,   // [2:0] command
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [7:0] read_green, [15:8] read_red, [23:16] read_blue, [24] bit_sent,
  // [25] bit_value, [34:26] high_time, [35] refresh_active
  output logic [lss_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast,  // frame_done
  input  logic                          cfg_wr_en,
  input  lss_pkg::cfg_idx_t             cfg_addr,
  input  logic [7:0]                    cfg_wr_data
);
  import lss_pkg::*;

  localparam int ROW_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam logic [7:0] PIX8     = 8'(PIXELS);
  localparam logic [4:0] LAST_BIT = 5'(BITS_PER_PIXEL - 1);

  // configuration
  logic [7:0] short_wait_r;
  logic [7:0] long_wait_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_wait_r <= SHORT_WAIT_RST;
      long_wait_r  <= LONG_WAIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_SHORT_WAIT: short_wait_r <= cfg_wr_data;
        CFG_LONG_WAIT:  long_wait_r  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // stage enables
  logic out_valid_r, s2_valid_r, s1_valid_r;
  logic out_en, s2_en, s1_en;

  assign out_en    = !out_valid_r || out_tready;
  assign s2_en     = !s2_valid_r || out_en;
  assign s1_en     = !s1_valid_r || s2_en;
  assign in_tready = s1_en;

  // input register
  cmd_t       s1_cmd_r;
  logic [5:0] s1_pix_r;
  rgb_t       s1_a_r, s1_b_r;
  frac_t      s1_frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_cmd_r  <= in_tuser;
      s1_pix_r  <= in_tdata[5:0];
      s1_a_r    <= {in_tdata[13:6], in_tdata[21:14], in_tdata[29:22]};
      s1_b_r    <= {in_tdata[37:30], in_tdata[45:38], in_tdata[53:46]};
      s1_frac_r <= in_tdata[65:54];
    end
  end

  // stage 1 decode
  logic [7:0]       s1_pix8;
  logic             s1_pix_ok;
  logic [7:0]       s1_mir8;
  logic [ROW_W-1:0] s1_row, s1_wr_row, s1_rd_row;
  logic             s1_wr, s1_tick;
  rgb_t             s1_color;

  assign s1_pix8   = {2'b00, s1_pix_r};
  assign s1_pix_ok = s1_pix8 < PIX8;
  assign s1_mir8   = PIX8 - s1_pix8;
  assign s1_row    = s1_pix8[ROW_W-1:0];

  // refresh counters: pixel row and bit within the pixel
  logic             sending_r;
  logic [ROW_W-1:0] pix_cnt_r;
  logic [4:0]       bit_cnt_r;
  logic             last_bit;

  assign s1_tick   = (s1_cmd_r == CMD_TICK) && sending_r;
  assign s1_rd_row = s1_tick ? pix_cnt_r : s1_row;
  assign last_bit  = (bit_cnt_r == LAST_BIT) && (32'(pix_cnt_r) == PIXELS - 1);

  always_comb begin
    s1_wr     = 1'b0;
    s1_wr_row = s1_row;
    case (s1_cmd_r)
      CMD_SCALE, CMD_BLEND: s1_wr = s1_pix_ok;
      CMD_MIRROR: begin
        s1_wr     = s1_pix_ok && (s1_pix_r != 6'd0);
        s1_wr_row = s1_mir8[ROW_W-1:0];
      end
      default: ;
    endcase
  end

  lss_color_unit u_color (
    .color_a  (s1_a_r),
    .color_b  (s1_b_r),
    .fraction (s1_frac_r),
    .blend    (s1_cmd_r == CMD_BLEND),
    .color_out(s1_color)
  );

  // refresh state advances as the item leaves stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r <= 1'b0;
      pix_cnt_r <= '0;
      bit_cnt_r <= '0;
    end else if (s1_valid_r && s2_en) begin
      if (s1_cmd_r == CMD_START) begin
        sending_r <= 1'b1;
      end else if (s1_tick) begin
        if (last_bit) begin
          sending_r <= 1'b0;
          pix_cnt_r <= '0;
          bit_cnt_r <= '0;
        end else if (bit_cnt_r == LAST_BIT) begin
          pix_cnt_r <= pix_cnt_r + 1'b1;
          bit_cnt_r <= '0;
        end else begin
          bit_cnt_r <= bit_cnt_r + 5'd1;
        end
      end
    end
  end

  // stage 2 register
  cmd_t             s2_cmd_r;
  logic             s2_pix_ok_r, s2_wr_r, s2_mirror_r, s2_sent_r, s2_done_r, s2_active_r;
  logic [ROW_W-1:0] s2_wr_row_r;
  logic [4:0]       s2_bit_r;
  rgb_t             s2_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_cmd_r    <= s1_cmd_r;
      s2_pix_ok_r <= s1_pix_ok;
      s2_wr_r     <= s1_wr;
      s2_mirror_r <= (s1_cmd_r == CMD_MIRROR);
      s2_wr_row_r <= s1_wr_row;
      s2_sent_r   <= s1_tick;
      s2_done_r   <= s1_tick && last_bit;
      s2_active_r <= (s1_cmd_r == CMD_START) || (sending_r && !(s1_tick && last_bit));
      s2_bit_r    <= bit_cnt_r;
      s2_color_r  <= s1_color;
    end
  end

  // frame store: read as the item enters stage 2, write as it leaves
  rgb_t rd_data, wr_data;
  logic wr_en;

  assign wr_en   = s2_valid_r && out_en && s2_wr_r;
  assign wr_data = s2_mirror_r ? rd_data : s2_color_r;

  lss_frame_store #(
    .PIXELS(PIXELS),
    .ROW_W (ROW_W)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (s2_en),
    .rd_addr(s1_rd_row),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(s2_wr_row_r),
    .wr_data(wr_data)
  );

  // result fields
  logic [23:0] rd_bits;
  logic [4:0]  bit_idx;
  logic        s2_bval;
  logic [8:0]  s2_htime;
  rgb_t        s2_read;

  assign rd_bits  = rd_data;
  assign bit_idx  = LAST_BIT - s2_bit_r;
  assign s2_bval  = s2_sent_r && rd_bits[bit_idx];
  assign s2_htime = s2_sent_r ? ({1'b0, short_wait_r} + (s2_bval ? {1'b0, long_wait_r} : 9'd0))
                              : 9'd0;
  assign s2_read  = (s2_cmd_r == CMD_READ && s2_pix_ok_r) ? rd_data : '0;

  // result register
  rgb_t       out_read_r;
  logic       out_sent_r, out_bval_r, out_active_r, out_done_r;
  logic [8:0] out_htime_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_read_r   <= s2_read;
      out_sent_r   <= s2_sent_r;
      out_bval_r   <= s2_bval;
      out_htime_r  <= s2_htime;
      out_active_r <= s2_active_r;
      out_done_r   <= s2_done_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_done_r;
  assign out_tdata  = {4'd0, out_active_r, out_htime_r, out_bval_r, out_sent_r,
                       out_read_r.blue, out_read_r.red, out_read_r.green};

  // checks
  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= LAST_BIT)
    else $error("bit counter beyond last bit of a pixel");

  a_pix_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pix_cnt_r) < PIXELS)
    else $error("pixel counter beyond strip length");

  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> (pix_cnt_r == '0 && bit_cnt_r == 5'd0))
    else $error("refresh counters not rewound while idle");

  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> (out_sent_r && !out_active_r))
    else $error("frame done without last bit or with refresh still active");

  a_no_pulse_no_time: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_sent_r) |-> (out_htime_r == 9'd0 && !out_bval_r))
    else $error("high time reported without a pulse");

endmodule

`default_nettype wire
